// File: rtl/btlpm_pkg.sv
// btlpm_pkg: shared types and codes of the binary trie longest prefix match engine
`timescale 1ns / 1ps

package btlpm_pkg;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_PUSH = 3'b100
  } state_e;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

// File: rtl/binary_trie_longest_prefix_match_top.sv
// binary_trie_longest_prefix_match_top: trie walk engine for route insert and longest prefix lookup
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------------------
//  in      | input     | in_valid_i / in_stall_o    | mode_i, address_key_i, prefix_len_i,
//          |           |                            | route_value_i
//  out     | output    | out_valid_o / out_stall_i  | found_o, route_out_o, status_o
//
//  a request walks L trie levels: in a lookup up to KEY_BITS + 1, in an insert up to prefix_len + 1,
//  with prefix_len taken as at most KEY_BITS
//  the node memory gives one read per cycle, so the walk advances one level per cycle
//  one request is worked at a time; the next is taken once the result sits in the output register
//  reset clears the root, held in flops, and the node count; no clearing pass over the memory
//  a stalled result holds in the output register while the next request is walked
`timescale 1ns / 1ps

module binary_trie_longest_prefix_match_top #(
  parameter int NODES      = 4096,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [KEY_BITS-1:0]   address_key_i,
  input  logic [5:0]            prefix_len_i,
  input  logic [VALUE_BITS-1:0] route_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  found_o,
  output logic [VALUE_BITS-1:0] route_out_o,
  output logic                  status_o
);
  import btlpm_pkg::*;

  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = $clog2(KEY_BITS + 1);
  localparam logic [IDX_W:0]   POOL_FULL  = (IDX_W + 1)'(NODES);
  localparam logic [CNT_W-1:0] KEY_LEVELS = CNT_W'(KEY_BITS);

  typedef struct packed {
    logic             mark;
    logic [IDX_W-1:0] l1;
    logic [IDX_W-1:0] l0;
  } node_t;

  node_t                 node_mem [NODES];
  logic [VALUE_BITS-1:0] val_mem  [NODES];

  state_e                state_q;
  node_t                 root_q, root_d;
  logic [VALUE_BITS-1:0] root_val_q, root_val_d;
  logic [IDX_W:0]        used_q;
  logic [IDX_W-1:0]      cur_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [CNT_W-1:0]      plen_q;
  logic [KEY_BITS-1:0]   key_q;
  logic                  mode_q;
  logic                  alloc_q;
  logic [VALUE_BITS-1:0] val_q;
  logic                  hit_q, hit_d;
  logic [VALUE_BITS-1:0] best_q, best_d;
  logic                  res_found_q;
  logic [VALUE_BITS-1:0] res_route_q;
  logic                  res_status_q;
  logic                  out_valid_q;
  logic                  out_found_q;
  logic [VALUE_BITS-1:0] out_route_q;
  logic                  out_status_q;

  node_t                 node_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;

  node_t                 ent;
  logic [VALUE_BITS-1:0] cur_val;
  logic                  key_bit;
  logic [IDX_W-1:0]      nxt;
  logic [IDX_W-1:0]      new_idx;
  logic [IDX_W-1:0]      rd_addr;
  logic                  nw_en;
  logic [IDX_W-1:0]      nw_addr;
  node_t                 nw_data;
  logic                  vw_en;
  logic                  advance;
  logic                  take_new;
  logic                  finish;
  logic                  full;
  logic                  in_take;
  logic                  out_load;
  logic [CNT_W-1:0]      plen_sat;

  assign in_take  = in_valid_i && (state_q == S_IDLE);
  assign out_load = (state_q == S_PUSH) && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (32'(prefix_len_i) > 32'(KEY_BITS)) begin
      plen_sat = KEY_LEVELS;
    end else begin
      plen_sat = CNT_W'(prefix_len_i);
    end
  end

  always_comb begin
    if (cur_q == '0) begin
      ent     = root_q;
      cur_val = root_val_q;
    end else begin
      ent     = alloc_q ? '0 : node_rd_q;
      cur_val = val_rd_q;
    end
    key_bit    = key_q[KEY_BITS-1];
    nxt        = key_bit ? ent.l1 : ent.l0;
    new_idx    = used_q[IDX_W-1:0];
    rd_addr    = nxt;
    nw_en      = 1'b0;
    nw_addr    = cur_q;
    nw_data    = ent;
    vw_en      = 1'b0;
    root_d     = root_q;
    root_val_d = root_val_q;
    advance    = 1'b0;
    take_new   = 1'b0;
    finish     = 1'b0;
    full       = 1'b0;
    hit_d      = hit_q;
    best_d     = best_q;
    if (in_take) begin
      hit_d  = 1'b0;
      best_d = '0;
    end
    if (state_q == S_WALK) begin
      if (mode_q == MODE_LOOKUP) begin
        if (ent.mark) begin
          hit_d  = 1'b1;
          best_d = cur_val;
        end
        if (cnt_q == KEY_LEVELS || nxt == '0) begin
          finish = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end else begin
        if (cnt_q == plen_q) begin
          finish       = 1'b1;
          nw_data.mark = 1'b1;
          if (cur_q == '0) begin
            root_d     = nw_data;
            root_val_d = val_q;
          end else begin
            nw_en = 1'b1;
            vw_en = 1'b1;
          end
        end else if (nxt != '0) begin
          advance = 1'b1;
        end else if (used_q == POOL_FULL) begin
          finish = 1'b1;
          full   = 1'b1;
          if (alloc_q) begin
            nw_en   = 1'b1;
            nw_data = '0;
          end
        end else begin
          take_new = 1'b1;
          if (key_bit) begin
            nw_data.l1 = new_idx;
          end else begin
            nw_data.l0 = new_idx;
          end
          if (cur_q == '0) begin
            root_d = nw_data;
          end else begin
            nw_en = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (nw_en) begin
      node_mem[nw_addr] <= nw_data;
    end
    node_rd_q <= node_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (vw_en) begin
      val_mem[cur_q] <= val_q;
    end
    val_rd_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      root_q      <= '0;
      used_q      <= (IDX_W + 1)'(1);
      cur_q       <= '0;
      cnt_q       <= '0;
      alloc_q     <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      root_q <= root_d;
      hit_q  <= hit_d;
      case (state_q)
        S_IDLE: begin
          if (in_take) begin
            state_q <= S_WALK;
            cur_q   <= '0;
            cnt_q   <= '0;
            alloc_q <= 1'b0;
          end
        end
        S_WALK: begin
          if (advance) begin
            cur_q <= nxt;
          end else if (take_new) begin
            cur_q   <= new_idx;
            alloc_q <= 1'b1;
            used_q  <= used_q + 1'b1;
          end
          if (advance || take_new) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (finish) begin
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    root_val_q <= root_val_d;
    best_q     <= best_d;
    if (in_take) begin
      key_q  <= address_key_i;
      mode_q <= mode_i;
      plen_q <= plen_sat;
      val_q  <= route_value_i;
    end else if (advance || take_new) begin
      key_q <= key_q << 1;
    end
    if (finish) begin
      if (mode_q == MODE_LOOKUP) begin
        res_found_q  <= hit_d;
        res_route_q  <= best_d;
        res_status_q <= STATUS_OK;
      end else begin
        res_found_q  <= 1'b0;
        res_route_q  <= '0;
        res_status_q <= full ? STATUS_FULL : STATUS_OK;
      end
    end
    if (out_load) begin
      out_found_q  <= res_found_q;
      out_route_q  <= res_route_q;
      out_status_q <= res_status_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign route_out_o = out_route_q;
  assign status_o    = out_status_q;

  // pool count stays within the node pool
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != '0) && (used_q <= POOL_FULL))
    else $error("node count out of range");

  // the root lives in flops and is never written to the node memory
  a_no_root_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nw_en |-> (nw_addr != '0))
    else $error("node memory write to root entry");

  // a freshly allocated node is never the root
  a_alloc_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && alloc_q) |-> (cur_q != '0))
    else $error("allocation walk points at root");

  // lookups never allocate nodes
  a_lookup_no_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && mode_q == MODE_LOOKUP) |=> $stable(used_q))
    else $error("node count changed during lookup");

  // a result moved out of the push state shows up on the output
  a_push_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && state_q == S_IDLE))
    else $error("result lost on output load");

endmodule

// File: sim/testbench.sv
// testbench: route insert and longest prefix lookup checked against a trie predictor
`timescale 1ns / 1ps

module testbench;
  import btlpm_pkg::*;

  localparam int TRIE_NODES  = 4096;
  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 32;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] route;
    logic               status;
  } route_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               mode_i = MODE_LOOKUP;
  logic [KEY_W-1:0]   address_key_i = '0;
  logic [5:0]         prefix_len_i = '0;
  logic [VALUE_W-1:0] route_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               found_o;
  logic [VALUE_W-1:0] route_out_o;
  logic               status_o;

  // predictor copy of the trie
  int unsigned        child_tbl [TRIE_NODES][2];
  bit                 mark_tbl  [TRIE_NODES];
  logic [VALUE_W-1:0] value_tbl [TRIE_NODES];
  int unsigned        used_nodes;

  route_result_t      expected_routes[$];
  route_result_t      head_route;
  logic [KEY_W-1:0]   known_keys[$];
  int                 errors = 0;
  int unsigned        cycle_count = 0;
  int                 burst_left = 0;
  int                 stall_count = 0;
  int                 stall_style = 0;

  binary_trie_longest_prefix_match_top #(
    .NODES     (TRIE_NODES),
    .KEY_BITS  (KEY_W),
    .VALUE_BITS(VALUE_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .address_key_i(address_key_i),
    .prefix_len_i (prefix_len_i),
    .route_value_i(route_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_o      (found_o),
    .route_out_o  (route_out_o),
    .status_o     (status_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic void clear_trie();
    for (int n = 0; n < TRIE_NODES; n++) begin
      child_tbl[n][0] = 0;
      child_tbl[n][1] = 0;
      mark_tbl[n]     = 1'b0;
      value_tbl[n]    = '0;
    end
    used_nodes = 1;
  endfunction

  function automatic route_result_t walk_trie(input logic mode, input logic [KEY_W-1:0] key,
                                              input logic [5:0] plen,
                                              input logic [VALUE_W-1:0] val);
    route_result_t res;
    int unsigned   node;
    int unsigned   nxt;
    int unsigned   depth;
    logic          bsel;
    bit            stop;
    res  = '0;
    node = 0;
    stop = 1'b0;
    if (mode == MODE_INSERT) begin
      depth = (plen > KEY_W) ? KEY_W : plen;
      for (int i = 0; i < depth && !stop; i++) begin
        bsel = key[KEY_W-1-i];
        nxt  = child_tbl[node][bsel];
        if (nxt == 0) begin
          if (used_nodes >= TRIE_NODES) begin
            stop = 1'b1;
          end else begin
            nxt = used_nodes;
            used_nodes++;
            child_tbl[nxt][0]     = 0;
            child_tbl[nxt][1]     = 0;
            mark_tbl[nxt]         = 1'b0;
            child_tbl[node][bsel] = nxt;
          end
        end
        if (!stop) node = nxt;
      end
      if (stop) begin
        res.status = STATUS_FULL;
      end else begin
        mark_tbl[node]  = 1'b1;
        value_tbl[node] = val;
        res.status      = STATUS_OK;
      end
    end else begin
      for (int i = 0; i < KEY_W && !stop; i++) begin
        bsel = key[KEY_W-1-i];
        if (mark_tbl[node]) begin
          res.found = 1'b1;
          res.route = value_tbl[node];
        end
        nxt = child_tbl[node][bsel];
        if (nxt == 0 || nxt >= TRIE_NODES) stop = 1'b1;
        else node = nxt;
      end
      // full depth reached: the end node itself may carry a /32
      if (!stop && mark_tbl[node]) begin
        res.found = 1'b1;
        res.route = value_tbl[node];
      end
      res.status = STATUS_OK;
    end
    return res;
  endfunction

  task automatic send_request(input logic mode, input logic [KEY_W-1:0] key,
                              input logic [5:0] plen, input logic [VALUE_W-1:0] val);
    int gap;
    mode_i        <= mode;
    address_key_i <= key;
    prefix_len_i  <= plen;
    route_value_i <= val;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_routes.push_back(walk_trie(mode, key, plen, val));
    if (mode == MODE_INSERT) known_keys.push_back(key);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [5:0] pick_prefix_len();
    int r;
    r = $urandom_range(0, 15);
    if (r < 12) return 6'($urandom_range(0, 24));
    else if (r < 15) return 6'($urandom_range(25, 32));
    else return 6'($urandom_range(33, 63));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    else if (r == 1) return '1;
    else return $urandom();
  endfunction

  // a key near a stored prefix: upper bits kept, a random tail flipped
  function automatic logic [KEY_W-1:0] near_key();
    logic [KEY_W-1:0] base;
    if (known_keys.size() == 0) return $urandom();
    base = known_keys[$urandom_range(0, known_keys.size() - 1)];
    if ($urandom_range(0, 5) == 0) return base;
    return base ^ ($urandom() >> $urandom_range(0, 31));
  endfunction

  task automatic test_directed_routes();
    send_request(MODE_LOOKUP, 32'h0000_0000, 6'd0, '0);
    send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 6'd63, '1);
    // default route
    send_request(MODE_INSERT, 32'h0000_0000, 6'd0, 32'h0000_000A);
    send_request(MODE_LOOKUP, 32'h1234_5678, 6'd0, '0);
    send_request(MODE_INSERT, 32'h8000_0000, 6'd1, 32'hFFFF_FFFF);
    send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 6'd0, '0);
    send_request(MODE_LOOKUP, 32'h7FFF_FFFF, 6'd0, '0);
    // full length route
    send_request(MODE_INSERT, 32'hC0A8_0101, 6'd32, 32'h1111_1111);
    send_request(MODE_LOOKUP, 32'hC0A8_0101, 6'd0, '0);
    send_request(MODE_LOOKUP, 32'hC0A8_0100, 6'd0, '0);
    send_request(MODE_INSERT, 32'hC0A8_0000, 6'd16, 32'h0000_0022);
    send_request(MODE_LOOKUP, 32'hC0A8_FFFF, 6'd0, '0);
    // overwrite an existing route
    send_request(MODE_INSERT, 32'hC0A8_0000, 6'd16, 32'h0000_0033);
    send_request(MODE_LOOKUP, 32'hC0A8_0001, 6'd0, '0);
    // prefix length above the key width
    send_request(MODE_INSERT, 32'hFFFF_FFFF, 6'd63, 32'h5A5A_5A5A);
    send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 6'd0, '0);
    send_request(MODE_INSERT, 32'h0000_0000, 6'd33, 32'h0000_0000);
    send_request(MODE_LOOKUP, 32'h0000_0000, 6'd0, '0);
    send_request(MODE_INSERT, 32'h0000_0000, 6'd0, 32'hFFFF_FFFF);
    send_request(MODE_LOOKUP, 32'h4000_0000, 6'd0, '0);
    send_request(MODE_INSERT, 32'h0000_0001, 6'd32, 32'hA5A5_A5A5);
    send_request(MODE_LOOKUP, 32'h0000_0001, 6'd0, '0);
    send_request(MODE_LOOKUP, 32'h0000_0002, 6'd0, '0);
  endtask

  task automatic test_random_routes(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 4) begin
        send_request(MODE_INSERT, ($urandom_range(0, 1) == 1) ? near_key() : $urandom(),
                     pick_prefix_len(), pick_value());
      end else begin
        send_request(MODE_LOOKUP, ($urandom_range(0, 4) != 0) ? near_key() : $urandom(),
                     6'($urandom_range(0, 63)), $urandom());
      end
    end
  endtask

  task automatic test_pool_exhaustion();
    while (used_nodes < TRIE_NODES) send_request(MODE_INSERT, $urandom(), 6'd32, pick_value());
    // pool is full now: new paths fail, existing ones still work
    for (int n = 0; n < 4; n++) send_request(MODE_INSERT, $urandom(), 6'd32, pick_value());
    send_request(MODE_INSERT, $urandom(), 6'd40, $urandom());
    send_request(MODE_INSERT, 32'h0000_0000, 6'd0, 32'h0BAD_F00D);
    send_request(MODE_INSERT, 32'hC0A8_0000, 6'd16, 32'h0000_0044);
    send_request(MODE_INSERT, 32'h8000_0000, 6'd1, 32'h0000_0055);
    for (int n = 0; n < 20; n++) send_request(MODE_LOOKUP, near_key(), 6'd0, '0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_routes.size() == 0) begin
        $display("%0t unexpected result: found %0d route %h status %0d",
                 $time, found_o, route_out_o, status_o);
        errors++;
      end else begin
        head_route = expected_routes.pop_front();
        if (found_o !== head_route.found) begin
          $display("%0t found mismatch: expected %0d actual %0d",
                   $time, head_route.found, found_o);
          errors++;
        end
        if (route_out_o !== head_route.route) begin
          $display("%0t route_out mismatch: expected %h actual %h",
                   $time, head_route.route, route_out_o);
          errors++;
        end
        if (status_o !== head_route.status) begin
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, head_route.status, status_o);
          errors++;
        end
      end
    end
  end

  // receiver backpressure in one of four random styles, each held for a random stretch
  always @(posedge clk_i) begin
    if (stall_count == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_count <= $urandom_range(20, 80);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_style)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 1) == 1);
      2: out_stall_i <= ($urandom_range(0, 7) != 0);
      default: out_stall_i <= cycle_count[2];
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clear_trie();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_routes();
    test_random_routes(300);
    test_pool_exhaustion();
    test_random_routes(60);
    in_valid_i <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
